// ===== rtl/core/ttdg_pkg.sv =====
`default_nettype none
package ttdg_pkg;

  // fixed field widths
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned CELL_W     = 8;
  localparam int unsigned KEY_W      = 8;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned COLORS_W   = 16;
  localparam int unsigned TILE_IDX_W = 6;
  localparam int unsigned BYTE_IDX_W = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // request kinds
  localparam logic REQ_CLEAR  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_KIND   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KIND_COLORS = 2'd3;

  // configuration reset values
  localparam logic [CELL_W-1:0]   GRID_WIDTH_RST  = 8'd40;
  localparam logic [CELL_W-1:0]   GRID_HEIGHT_RST = 8'd36;
  localparam logic [KIND_W-1:0]   WALL_KIND_RST   = 2'd1;
  localparam logic [COLORS_W-1:0] KIND_COLORS_RST = 16'h4321;

  // last byte of a tile
  localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = 5'd31;

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [KEY_W-1:0]  key_t;

  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] block_x;
    logic [POS_W-1:0] block_y;
    kind_t            kind_top_left;
    kind_t            kind_top_right;
    kind_t            kind_bottom_left;
    kind_t            kind_bottom_right;
  } tile_req_t;

  typedef struct packed {
    logic [TILE_IDX_W-1:0] tile_index;
    logic                  is_new;
    logic                  table_full;
    logic [BYTE_IDX_W-1:0] byte_index;
    logic [BYTE_W-1:0]     tile_byte;
    logic                  last;
  } tile_res_t;

  // colour nibble of one kind
  function automatic logic [COLOR_W-1:0] color_of(input logic [COLORS_W-1:0] colors,
                                                  input kind_t kind);
    return colors[{kind, 2'b00} +: COLOR_W];
  endfunction

  // planar byte: row = bidx[4:2], plane = bidx[1:0]; rows 4..7 use the lower cells
  function automatic logic [BYTE_W-1:0] tile_byte_of(input logic [COLORS_W-1:0] colors,
                                                     input key_t key,
                                                     input logic [BYTE_IDX_W-1:0] bidx);
    kind_t             kl;
    kind_t             kr;
    logic [COLOR_W-1:0] cl;
    logic [COLOR_W-1:0] cr;
    kl = bidx[4] ? key[5:4] : key[1:0];
    kr = bidx[4] ? key[7:6] : key[3:2];
    cl = color_of(colors, kl);
    cr = color_of(colors, kr);
    return {{4{cl[bidx[1:0]]}}, {4{cr[bidx[1:0]]}}};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ttdg_ifs.sv =====
`default_nettype none
interface ttdg_req_if;
  import ttdg_pkg::*;

  logic      valid;
  logic      ready;
  tile_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ttdg_res_if;
  import ttdg_pkg::*;

  logic      valid;
  logic      ready;
  tile_res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/terrain_tile_dedup_generator.sv =====
// clear request: accepted while idle, empties the pattern table, no result
// lookup: key search walks the stored keys one per cycle through a single compare,
//   ending in a hit or full answer; on a miss with room a new tile then streams
//   32 bytes, one per cycle while the sink is ready
// one request at a time; throughput set by the search loop and the byte stream
// reset: pattern table empty, config registers at defaults; key store not cleared
`default_nettype none
module terrain_tile_dedup_generator #(
  parameter int unsigned PATTERN_SLOTS = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  ttdg_req_if.sink                            req,
  ttdg_res_if.source                          res,
  input  wire                                 cfg_write,
  input  wire [ttdg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ttdg_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ttdg_pkg::*;

  localparam int unsigned IDX_W = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(PATTERN_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(PATTERN_SLOTS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESP   = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  // configuration registers
  logic [CELL_W-1:0]   grid_width;
  logic [CELL_W-1:0]   grid_height;
  kind_t               wall_kind;
  logic [COLORS_W-1:0] kind_colors;

  // control and working registers
  logic [1:0]            state;
  logic [CNT_W-1:0]      entry_count;
  logic [CNT_W-1:0]      ptr;
  logic                  cmp_valid;
  logic [IDX_W-1:0]      cmp_idx;
  key_t                  rd_data;
  key_t                  key;
  logic [IDX_W-1:0]      slot;
  logic                  resp_full;
  logic [BYTE_IDX_W-1:0] byte_cnt;
  logic                  out_valid;
  tile_res_t             out_data;

  key_t key_store [PATTERN_SLOTS];

  // cell kinds with the wall substitution
  tile_req_t        r;
  logic [CELL_W-1:0] x0, x1, y0, y1;
  kind_t            k_tl, k_tr, k_bl, k_br;
  key_t             new_key;

  always_comb begin
    r = req.payload;
    x0 = {r.block_x, 1'b0};
    x1 = {r.block_x, 1'b1};
    y0 = {r.block_y, 1'b0};
    y1 = {r.block_y, 1'b1};
    k_tl = (x0 < grid_width && y0 < grid_height) ? r.kind_top_left     : wall_kind;
    k_tr = (x1 < grid_width && y0 < grid_height) ? r.kind_top_right    : wall_kind;
    k_bl = (x0 < grid_width && y1 < grid_height) ? r.kind_bottom_left  : wall_kind;
    k_br = (x1 < grid_width && y1 < grid_height) ? r.kind_bottom_right : wall_kind;
    new_key = {k_br, k_bl, k_tr, k_tl};
  end

  // handshake and search decisions
  logic accept;
  logic out_free;
  logic load_out;
  logic issue;
  logic hit;
  logic miss;
  logic is_full;
  logic [IDX_W+TILE_IDX_W-1:0] slot_ext;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || res.ready;
  assign load_out = out_free && ((state == ST_RESP) || (state == ST_EMIT));
  assign issue    = (state == ST_SEARCH) && (ptr < entry_count);
  assign hit      = (state == ST_SEARCH) && cmp_valid && (rd_data == key);
  assign miss     = (state == ST_SEARCH) && !cmp_valid && !issue;
  assign is_full  = entry_count >= SLOTS_C;
  assign slot_ext = {{TILE_IDX_W{1'b0}}, slot};

  assign req.ready   = (state == ST_IDLE);
  assign res.valid   = out_valid;
  assign res.payload = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      wall_kind   <= WALL_KIND_RST;
      kind_colors <= KIND_COLORS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[CELL_W-1:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[CELL_W-1:0];
        CFG_WALL_KIND:   wall_kind   <= cfg_data[KIND_W-1:0];
        CFG_KIND_COLORS: kind_colors <= cfg_data[COLORS_W-1:0];
        default: ;
      endcase
    end
  end

  // key store: one read port for the search, one write on a miss with room
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= key_store[ptr[IDX_W-1:0]];
    end
    if (miss && !is_full) begin
      key_store[entry_count[IDX_W-1:0]] <= key;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      cmp_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // output register: load a new result or drop the one taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (r.req_type == REQ_CLEAR) begin
              entry_count <= '0;
            end else begin
              key       <= new_key;
              ptr       <= '0;
              cmp_valid <= 1'b0;
              state     <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          // compare the entry read last cycle, issue the next read
          cmp_valid <= issue;
          cmp_idx   <= ptr[IDX_W-1:0];
          if (issue) begin
            ptr <= ptr + 1'b1;
          end
          if (hit) begin
            slot      <= cmp_idx;
            resp_full <= 1'b0;
            state     <= ST_RESP;
          end else if (miss) begin
            if (is_full) begin
              slot      <= '0;
              resp_full <= 1'b1;
              state     <= ST_RESP;
            end else begin
              slot        <= entry_count[IDX_W-1:0];
              entry_count <= entry_count + 1'b1;
              byte_cnt    <= '0;
              state       <= ST_EMIT;
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_data.tile_index <= slot_ext[TILE_IDX_W-1:0];
            out_data.is_new     <= 1'b0;
            out_data.table_full <= resp_full;
            out_data.byte_index <= '0;
            out_data.tile_byte  <= '0;
            out_data.last       <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // one tile byte per free output slot
          if (out_free) begin
            out_data.tile_index <= slot_ext[TILE_IDX_W-1:0];
            out_data.is_new     <= 1'b1;
            out_data.table_full <= 1'b0;
            out_data.byte_index <= byte_cnt;
            out_data.tile_byte  <= tile_byte_of(kind_colors, key, byte_cnt);
            out_data.last       <= (byte_cnt == LAST_BYTE);
            byte_cnt            <= byte_cnt + 1'b1;
            if (byte_cnt == LAST_BYTE) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
